/* hw/rtl/tse_pkg.sv */
// Shared types and constants for the topological sort engine.
// No dependencies.
`default_nettype none
package tse_pkg;
    localparam int NODES     = 16;
    localparam int MAX_EDGES = 64;
    localparam int NODE_W    = 5;
    localparam int EDGE_AW   = 6;
    localparam int EDGE_CW   = 7;
    localparam int DEG_W     = 7;
    localparam int NIDX_W    = 4;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CYCLE    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INIT, S_POP, S_SCAN_RD, S_SCAN, S_EMIT, S_SINGLE
    } tse_state_t;

    typedef struct packed {
        logic clear;
        logic add;
        logic drop;
        logic init_start;
        logic init_step;
        logic pop;
        logic scan_start;
        logic scan_step;
        logic emit_start;
        logic emit_step;
    } tse_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic full;
        logic overflow;
        logic init_done;
        logic queue_empty;
        logic pop_done;
        logic scan_done;
        logic emit_last;
    } tse_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/topological_sort_engine_unit.sv */
// Top level of the topological sort engine.
// Depends on tse_pkg, tse_ctrl and tse_datapath.
// A run scans the stored edge list, one edge a cycle, for every popped
// node; results leave through a registered output stage. Only one
// request is in work at a time.
`default_nettype none
module topological_sort_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // op[1:0], edge_from[6:2], edge_to[11:7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // node[4:0], status[6:5]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);
    import tse_pkg::*;

    tse_cmd_t          cmd;
    tse_stat_t         stat;
    logic [NODE_W-1:0] node_count_reg, emit_node;
    logic              out_load, out_single, out_last, out_free;
    logic [1:0]        out_status;
    logic [NODE_W-1:0] from_reg, to_reg;
    logic              valid_reg, last_reg;
    logic [6:0]        data_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_W'(NODES);
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            from_reg <= s_tdata[6:2];
            to_reg   <= s_tdata[11:7];
        end
        if (out_load) begin
            data_reg <= {out_status, out_single ? NODE_W'(0) : emit_node};
            last_reg <= out_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg};
    assign m_tlast  = last_reg;

    tse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .op(s_tdata[1:0]), .stat(stat), .cmd(cmd), .out_load(out_load),
        .out_single(out_single), .out_status(out_status), .out_last(out_last),
        .out_free(out_free));

    tse_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .edge_from(from_reg), .edge_to(to_reg), .node_count(node_count_reg),
        .emit_node(emit_node));

    logic unused_ok;
    assign unused_ok = ^s_tdata[15:12];
endmodule
`default_nettype wire

/* hw/rtl/tse_ram.sv */
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
`default_nettype none
module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/tse_datapath.sv */
// Datapath of the topological sort engine: edge memories, in-degrees, queue.
// Depends on tse_pkg and tse_ram.
`default_nettype none
module tse_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tse_pkg::tse_cmd_t             cmd,
    output tse_pkg::tse_stat_t                 stat,
    input  wire logic [tse_pkg::NODE_W-1:0]    edge_from,
    input  wire logic [tse_pkg::NODE_W-1:0]    edge_to,
    input  wire logic [tse_pkg::NODE_W-1:0]    node_count,
    output logic      [tse_pkg::NODE_W-1:0]    emit_node
);
    import tse_pkg::*;

    logic [EDGE_CW-1:0] edge_cnt_reg, edge_cnt_next;
    logic               ovf_reg, ovf_next;
    logic [DEG_W-1:0]   deg_reg [NODES];
    logic [DEG_W-1:0]   work_reg [NODES];
    logic [NODE_W-1:0]  queue_reg [NODES];
    logic [NODE_W-1:0]  head_reg, tail_reg;
    logic [NODE_W-1:0]  cur_reg;
    logic [NODE_W-1:0]  idx_reg;
    logic [EDGE_CW-1:0] eidx_reg;
    logic [NODE_W-1:0]  src_rd, dst_rd;
    logic [NODE_W-1:0]  n_act;
    logic [EDGE_AW-1:0] raddr;

    assign n_act = (node_count == '0) ? NODE_W'(1) :
                   (node_count > NODE_W'(NODES)) ? NODE_W'(NODES) : node_count;
    assign raddr = cmd.scan_start ? '0 : eidx_reg[EDGE_AW-1:0];

    tse_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_src (
        .aclk(aclk), .we(cmd.add), .waddr(edge_cnt_reg[EDGE_AW-1:0]),
        .wdata(edge_from), .raddr(raddr), .rdata(src_rd));
    tse_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_dst (
        .aclk(aclk), .we(cmd.add), .waddr(edge_cnt_reg[EDGE_AW-1:0]),
        .wdata(edge_to), .raddr(raddr), .rdata(dst_rd));

    always_comb begin
        stat.edge_ok     = (edge_from != '0) && (edge_from <= NODE_W'(NODES)) &&
                           (edge_to != '0) && (edge_to <= NODE_W'(NODES));
        stat.full        = (edge_cnt_reg == EDGE_CW'(MAX_EDGES));
        stat.overflow    = ovf_reg;
        stat.init_done   = (idx_reg + NODE_W'(1) >= n_act);
        stat.queue_empty = (head_reg >= tail_reg);
        stat.pop_done    = (idx_reg >= n_act);
        stat.scan_done   = (eidx_reg > edge_cnt_reg);
        stat.emit_last   = (idx_reg + NODE_W'(1) >= n_act);
        edge_cnt_next    = edge_cnt_reg;
        ovf_next         = ovf_reg;
        if (cmd.clear) begin
            edge_cnt_next = '0;
            ovf_next      = 1'b0;
        end else if (cmd.add) begin
            edge_cnt_next = edge_cnt_reg + EDGE_CW'(1);
        end else if (cmd.drop) begin
            ovf_next = 1'b1;
        end
    end

    assign emit_node = queue_reg[idx_reg[NIDX_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            for (int i = 0; i < NODES; i++) begin
                deg_reg[i] <= '0;
            end
        end else begin
            edge_cnt_reg <= edge_cnt_next;
            ovf_reg      <= ovf_next;
            if (cmd.clear) begin
                for (int i = 0; i < NODES; i++) begin
                    deg_reg[i] <= '0;
                end
            end
            if (cmd.add) begin
                deg_reg[edge_to[NIDX_W-1:0] - NIDX_W'(1)] <=
                    deg_reg[edge_to[NIDX_W-1:0] - NIDX_W'(1)] + DEG_W'(1);
            end
            if (cmd.init_start) begin
                for (int i = 0; i < NODES; i++) begin
                    work_reg[i] <= deg_reg[i];
                end
                head_reg <= '0;
                tail_reg <= '0;
                idx_reg  <= '0;
            end
            if (cmd.init_step) begin
                if (work_reg[idx_reg[NIDX_W-1:0]] == '0) begin
                    queue_reg[tail_reg[NIDX_W-1:0]] <= idx_reg + NODE_W'(1);
                    tail_reg <= tail_reg + NODE_W'(1);
                end
                idx_reg <= stat.init_done ? '0 : idx_reg + NODE_W'(1);
            end
            if (cmd.pop) begin
                cur_reg  <= queue_reg[head_reg[NIDX_W-1:0]];
                head_reg <= head_reg + NODE_W'(1);
                idx_reg  <= idx_reg + NODE_W'(1);
            end
            if (cmd.scan_start) begin
                eidx_reg <= EDGE_CW'(1);
            end
            if (cmd.scan_step) begin
                eidx_reg <= eidx_reg + EDGE_CW'(1);
                if (src_rd == cur_reg && dst_rd != '0 && dst_rd <= n_act &&
                    work_reg[dst_rd[NIDX_W-1:0] - NIDX_W'(1)] != '0) begin
                    work_reg[dst_rd[NIDX_W-1:0] - NIDX_W'(1)] <=
                        work_reg[dst_rd[NIDX_W-1:0] - NIDX_W'(1)] - DEG_W'(1);
                    if (work_reg[dst_rd[NIDX_W-1:0] - NIDX_W'(1)] == DEG_W'(1) &&
                        tail_reg < NODE_W'(NODES)) begin
                        queue_reg[tail_reg[NIDX_W-1:0]] <= dst_rd;
                        tail_reg <= tail_reg + NODE_W'(1);
                    end
                end
            end
            if (cmd.emit_start) begin
                idx_reg <= '0;
            end
            if (cmd.emit_step) begin
                idx_reg <= idx_reg + NODE_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/tse_ctrl.sv */
// Controller state machine of the topological sort engine.
// Depends on tse_pkg.
`default_nettype none
module tse_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         op,
    input  wire tse_pkg::tse_stat_t stat,
    output tse_pkg::tse_cmd_t       cmd,
    output logic                    out_load,
    output logic                    out_single,
    output logic [1:0]              out_status,
    output logic                    out_last,
    input  wire logic               out_free
);
    import tse_pkg::*;

    tse_state_t state_reg, state_next;
    logic [1:0] op_reg;
    logic [1:0] st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (s_tvalid && s_tready) begin
            op_reg <= op;
        end
        st_reg <= st_next;
    end

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                if (op_reg == OP_ADD && stat.edge_ok && stat.full) begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_SINGLE;
                end else if (op_reg == OP_RUN) begin
                    if (stat.overflow) begin
                        st_next    = ST_OVERFLOW;
                        state_next = S_SINGLE;
                    end else begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (stat.init_done) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                if (stat.pop_done) begin
                    state_next = S_EMIT;
                end else if (stat.queue_empty) begin
                    st_next    = ST_CYCLE;
                    state_next = S_SINGLE;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: state_next = S_SCAN;
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_POP;
                end
            end
            S_EMIT: begin
                if (out_free && stat.emit_last) begin
                    state_next = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        out_single = 1'b0;
        out_status = ST_OK;
        out_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_DECODE: begin
                cmd.clear      = (op_reg == OP_CLEAR);
                cmd.add        = (op_reg == OP_ADD) && stat.edge_ok && !stat.full;
                cmd.drop       = (op_reg == OP_ADD) && stat.edge_ok && stat.full;
                cmd.init_start = (op_reg == OP_RUN);
            end
            S_INIT:   cmd.init_step = 1'b1;
            S_POP: begin
                cmd.pop        = !stat.pop_done && !stat.queue_empty;
                cmd.emit_start = stat.pop_done;
            end
            S_SCAN_RD: cmd.scan_start = 1'b1;
            S_SCAN:    cmd.scan_step  = !stat.scan_done;
            S_EMIT: begin
                out_load      = out_free;
                out_last      = stat.emit_last;
                cmd.emit_step = out_free;
            end
            S_SINGLE: begin
                out_load   = out_free;
                out_single = 1'b1;
                out_status = st_reg;
                out_last   = 1'b1;
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* tb/topological_sort_engine_unit_checker.sv */
// Checker for the topological sort engine: watches the request, result and register ports,
// predicts every result of the sort and compares it field by field.
// Depends on tse_pkg.
`default_nettype none
module topological_sort_engine_unit_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    output int               fails,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tse_pkg::*;

    typedef struct packed {
        logic [4:0] node;
        logic [1:0] status;
        logic       last;
    } sort_result_t;

    sort_result_t    order_fifo[$];
    logic [4:0]      node_setting;
    logic [4:0]      src_mem[MAX_EDGES];
    logic [4:0]      dst_mem[MAX_EDGES];
    int              edge_total;
    int              indeg[NODES];
    bit              store_overflowed;

    assign pending = order_fifo.size();

    function automatic void push_single(logic [1:0] st);
        sort_result_t r;
        r = '{node: 5'd0, status: st, last: 1'b1};
        order_fifo = {order_fifo, r};
    endfunction

    function automatic void kahn_sort();
        int n;
        int work[NODES];
        logic [4:0] ready_q[NODES];
        logic [4:0] sorted[NODES];
        int head;
        int tail;
        logic [4:0] x;
        int t;
        sort_result_t r;
        n = (node_setting == 0) ? 1 : (node_setting > NODES) ? NODES : int'(node_setting);
        if (store_overflowed) begin
            push_single(ST_OVERFLOW);
            return;
        end
        head = 0;
        tail = 0;
        for (int i = 0; i < n; i++) begin
            work[i] = indeg[i];
            if (work[i] == 0) begin
                ready_q[tail] = 5'(i + 1);
                tail++;
            end
        end
        for (int k = 0; k < n; k++) begin
            if (head >= tail) begin
                push_single(ST_CYCLE);
                return;
            end
            x = ready_q[head];
            head++;
            sorted[k] = x;
            for (int e = 0; e < edge_total; e++) begin
                t = dst_mem[e];
                if (src_mem[e] == x && t != 0 && t <= n && work[t-1] > 0) begin
                    work[t-1]--;
                    if (work[t-1] == 0 && tail < NODES) begin
                        ready_q[tail] = 5'(t);
                        tail++;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            r = '{node: sorted[k], status: ST_OK, last: (k == n - 1)};
            order_fifo = {order_fifo, r};
        end
    endfunction

    function automatic void apply_request(logic [1:0] op, logic [4:0] f, logic [4:0] t);
        case (op)
            OP_CLEAR: begin
                edge_total = 0;
                store_overflowed = 0;
                foreach (indeg[i]) indeg[i] = 0;
            end
            OP_ADD: begin
                if (f != 0 && f <= NODES && t != 0 && t <= NODES) begin
                    if (edge_total >= MAX_EDGES) begin
                        store_overflowed = 1;
                        push_single(ST_OVERFLOW);
                    end else begin
                        src_mem[edge_total] = f;
                        dst_mem[edge_total] = t;
                        edge_total++;
                        indeg[t-1]++;
                    end
                end
            end
            OP_RUN: kahn_sort();
            default: ;
        endcase
    endfunction

    initial fails = 0;

    always @(posedge aclk) begin
        sort_result_t want;
        if (!aresetn) begin
            node_setting = 5'd16;
            edge_total = 0;
            store_overflowed = 0;
            foreach (indeg[i]) indeg[i] = 0;
            order_fifo.delete();
        end else begin
            if (cfg_we)
                node_setting = cfg_wdata;
            if (s_tvalid && s_tready)
                apply_request(s_tdata[1:0], s_tdata[6:2], s_tdata[11:7]);
            if (m_tvalid && m_tready) begin
                if (order_fifo.size() == 0) begin
                    $error("unexpected result node=%0d status=%0d last=%0b",
                           m_tdata[4:0], m_tdata[6:5], m_tlast);
                    fails++;
                end else begin
                    want = order_fifo.pop_front();
                    if (m_tdata[4:0] !== want.node) begin
                        $error("node: expected %0d, got %0d", want.node, m_tdata[4:0]);
                        fails++;
                    end
                    if (m_tdata[6:5] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[6:5]);
                        fails++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* tb/topological_sort_engine_unit_tb.sv */
// Top of the topological sort engine testbench: clock, reset, request stimulus,
// result-side back-pressure and the verdict. Depends on tse_pkg, the engine and its checker.
`default_nettype none
module topological_sort_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tse_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    int          fails;
    int          pending;
    int          cycles;
    int          sent;
    bit          quiet;
    bit          hold_req;

    topological_sort_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    topological_sort_engine_unit_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fails(fails), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (500) @(posedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic send_req(logic [1:0] op, logic [4:0] f, logic [4:0] t);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, t, f, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_nodes(logic [4:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic graph_phase(int kind);
        logic [4:0] perm[16];
        logic [4:0] tmp;
        int j;
        int a;
        int b;
        for (int i = 0; i < 16; i++) perm[i] = 5'(i + 1);
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        send_req(OP_CLEAR, 5'($urandom), 5'($urandom));
        if (kind == 9) begin
            repeat ($urandom_range(65, 67))
                send_req(OP_ADD, 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
        end else begin
            repeat ($urandom_range(0, 24)) begin
                a = $urandom_range(0, 14);
                b = $urandom_range(a + 1, 15);
                send_req(OP_ADD, perm[a], perm[b]);
                if ($urandom_range(0, 9) == 0)
                    send_req(2'($urandom), 5'($urandom), 5'($urandom));
            end
            if (kind == 8) begin
                a = $urandom_range(0, 14);
                b = $urandom_range(a + 1, 15);
                send_req(OP_ADD, perm[b], perm[a]);
            end
        end
        repeat ($urandom_range(1, 2)) send_req(OP_RUN, 5'($urandom), 5'($urandom));
    endtask

    initial begin
        int pick;
        logic [4:0] v;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        sent = 0;
        quiet = 0;
        hold_req = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_nodes(5'd16);
        send_req(OP_CLEAR, 5'd0, 5'd0);
        send_req(OP_ADD, 5'd1, 5'd2);
        send_req(OP_ADD, 5'd2, 5'd3);
        send_req(OP_ADD, 5'd1, 5'd3);
        send_req(OP_RUN, 5'd0, 5'd0);
        send_req(OP_ADD, 5'd0, 5'd5);
        send_req(OP_ADD, 5'd17, 5'd1);
        send_req(OP_ADD, 5'd31, 5'd31);
        send_req(2'd3, 5'd31, 5'd31);
        send_req(OP_RUN, 5'd31, 5'd31);
        send_req(OP_ADD, 5'd16, 5'd15);
        send_req(OP_ADD, 5'd15, 5'd16);
        send_req(OP_RUN, 5'd0, 5'd0);
        send_req(OP_CLEAR, 5'd31, 5'd31);
        send_req(OP_RUN, 5'd0, 5'd0);
        set_nodes(5'd4);
        send_req(OP_ADD, 5'd16, 5'd2);
        send_req(OP_ADD, 5'd1, 5'd16);
        send_req(OP_RUN, 5'd0, 5'd0);
        set_nodes(5'd0);
        send_req(OP_RUN, 5'd0, 5'd0);
        set_nodes(5'd31);
        send_req(OP_RUN, 5'd0, 5'd0);
        set_nodes(5'd1);
        send_req(OP_RUN, 5'd0, 5'd0);

        hold_req = 1;
        while (sent < 300) begin
            if (sent > 250) quiet = 1;
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 4);
                v = (pick == 0) ? 5'd1 : (pick == 1) ? 5'd16 : (pick == 2) ? 5'd0 :
                    (pick == 3) ? 5'd31 : 5'($urandom_range(2, 16));
                set_nodes(v);
            end
            graph_phase($urandom_range(0, 9));
        end

        drain();
        repeat (50) @(posedge aclk);
        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/tse_pkg.sv
hw/rtl/tse_ram.sv
hw/rtl/tse_datapath.sv
hw/rtl/tse_ctrl.sv
hw/rtl/topological_sort_engine_unit.sv
tb/topological_sort_engine_unit_checker.sv
tb/topological_sort_engine_unit_tb.sv
